FILE: hdl/tia_pkg.sv
// ----------------------------------------------------------------------------
// Time interval aligner package
// Shared widths, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tia_pkg;

   // Field widths.
   localparam int TimeWidth     = 32;
   localparam int BoundWidth    = 33;
   localparam int IntervalWidth = 17;

   // Configuration port.
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int CsrIdxWidth  = 1;

   // Register indexes, taken from the word address.
   localparam logic [CsrIdxWidth-1:0] RegIntervalIdx = 1'b0;

   // The remainder divider retires one dividend bit a cycle.
   localparam int DivSteps     = BoundWidth;
   localparam int DivCntWidth  = $clog2(DivSteps + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic fb_write;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
   } status_type;

endpackage

FILE: hdl/tia_div.sv
// ----------------------------------------------------------------------------
// Time interval aligner remainder divider
// Restoring division, one dividend bit a cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module tia_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tia_pkg::BoundWidth-1:0]      dividend,
   input  logic [tia_pkg::IntervalWidth-1:0]   divisor,
   output logic                                done,
   output logic [tia_pkg::IntervalWidth-1:0]   remainder
);
   import tia_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DivCntWidth-1:0]     cnt_ff, cnt_in;
   logic [BoundWidth-1:0]      dvd_ff, dvd_in;
   logic [IntervalWidth-1:0]   rem_ff, rem_in;
   logic [IntervalWidth-1:0]   dsr_ff, dsr_in;
   logic [IntervalWidth:0]     trial;

   // One restoring step: bring down the next bit and subtract if it fits.
   always_comb begin
      trial   = {rem_ff, dvd_ff[BoundWidth-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DivCntWidth'(DivSteps);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = IntervalWidth'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = IntervalWidth'(trial);
         end
         dvd_in = {dvd_ff[BoundWidth-2:0], 1'b0};
         cnt_in = cnt_ff - DivCntWidth'(1);
         if (cnt_ff == DivCntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the operands need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/tia_dpath.sv
// ----------------------------------------------------------------------------
// Time interval aligner datapath
// Holds the window state, the first-boundary divider and the result register.
// ----------------------------------------------------------------------------
module tia_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  tia_pkg::cmd_type                    cmd,
   output tia_pkg::status_type                 status,
   input  logic [tia_pkg::IntervalWidth-1:0]   interval,
   input  logic [tia_pkg::TimeWidth-1:0]       record_time,
   output logic                                rsp_accept,
   output logic                                rsp_window_closed,
   output logic [tia_pkg::BoundWidth-1:0]      rsp_closed_start,
   output logic [tia_pkg::BoundWidth-1:0]      rsp_closed_end,
   output logic [tia_pkg::BoundWidth-1:0]      rsp_current_start,
   output logic [tia_pkg::TimeWidth-1:0]       rsp_last_time
);
   import tia_pkg::*;

   logic [TimeWidth-1:0]     max_time_ff, t_ff, t_in;
   logic [BoundWidth-1:0]    fb_ff;
   logic                     first_known_ff;
   logic                     started_ff, started_in;
   logic [BoundWidth-1:0]    ws_ff, ws_in;
   logic [BoundWidth-1:0]    nb_ff, nb_in;
   logic [TimeWidth-1:0]     latest_ff, latest_in;

   logic                     acc_in, closed_in;
   logic [BoundWidth-1:0]    cs_in, ce_in;

   logic                     out_acc_ff, out_closed_ff;
   logic [BoundWidth-1:0]    out_cs_ff, out_ce_ff, out_ws_ff;
   logic [TimeWidth-1:0]     out_latest_ff;

   logic [BoundWidth-1:0]    t_ext, iv_ext, round_sum;
   logic                     div_done;
   logic [IntervalWidth-1:0] div_rem;

   // The running maximum keeps time monotonic.
   assign t_in   = (record_time > max_time_ff) ? record_time : max_time_ff;
   assign t_ext  = {1'b0, t_ff};
   assign iv_ext = {{(BoundWidth-IntervalWidth){1'b0}}, interval};

   // The first boundary is (t + iv - 1) less its remainder modulo iv.
   assign round_sum = t_ext + iv_ext - BoundWidth'(1);

   tia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (round_sum),
      .divisor   (interval),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign status.need_div = (interval != '0) && !started_ff && !first_known_ff;
   assign status.div_done = div_done;

   // Window update for the held record.
   always_comb begin
      acc_in     = 1'b1;
      closed_in  = 1'b0;
      cs_in      = '0;
      ce_in      = '0;
      ws_in      = ws_ff;
      nb_in      = nb_ff;
      started_in = started_ff;
      latest_in  = latest_ff;
      if (interval == '0) begin
         if (!started_ff) begin
            ws_in      = t_ext;
            started_in = 1'b1;
         end
         latest_in = t_ff;
      end else begin
         if (!started_ff) begin
            if (t_ext < fb_ff) begin
               acc_in = 1'b0;
            end else begin
               ws_in      = fb_ff;
               nb_in      = fb_ff + iv_ext;
               started_in = 1'b1;
            end
         end
         if (acc_in) begin
            if (t_ext >= nb_in) begin
               closed_in = 1'b1;
               cs_in     = ws_in;
               ce_in     = nb_in;
               ws_in     = nb_in;
               nb_in     = nb_in + iv_ext;
            end
            latest_in = t_ff;
         end
      end
   end

   // Window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_time_ff    <= '0;
         fb_ff          <= '0;
         first_known_ff <= 1'b0;
         started_ff     <= 1'b0;
         ws_ff          <= '0;
         nb_ff          <= '0;
         latest_ff      <= '0;
      end else begin
         if (cmd.load) begin
            max_time_ff <= t_in;
         end
         if (cmd.fb_write) begin
            fb_ff          <= round_sum - {{(BoundWidth-IntervalWidth){1'b0}}, div_rem};
            first_known_ff <= 1'b1;
         end
         if (cmd.commit) begin
            started_ff <= started_in;
            ws_ff      <= ws_in;
            nb_ff      <= nb_in;
            latest_ff  <= latest_in;
         end
      end
   end

   // Held record and result register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff <= t_in;
      end
      if (cmd.commit) begin
         out_acc_ff    <= acc_in;
         out_closed_ff <= closed_in;
         out_cs_ff     <= cs_in;
         out_ce_ff     <= ce_in;
         out_ws_ff     <= ws_in;
         out_latest_ff <= latest_in;
      end
   end

   assign rsp_accept        = out_acc_ff;
   assign rsp_window_closed = out_closed_ff;
   assign rsp_closed_start  = out_cs_ff;
   assign rsp_closed_end    = out_ce_ff;
   assign rsp_current_start = out_ws_ff;
   assign rsp_last_time     = out_latest_ff;

endmodule

FILE: hdl/tia_ctrl.sv
// ----------------------------------------------------------------------------
// Time interval aligner controller
// Sequences each request through the window update and, on the first
// windowed record, through the first-boundary division.
// ----------------------------------------------------------------------------
module tia_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tia_pkg::status_type  status,
   output tia_pkg::cmd_type     cmd
);
   import tia_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State register and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.fb_write = 1'b1;
               state_in     = ST_CALC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register fills on commit and empties when taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/time_interval_aligner.sv
// ----------------------------------------------------------------------------
// Time interval aligner
// One request at a time: loaded in ST_IDLE, committed to the result register
// in ST_CALC, which waits while an earlier result is untaken. The first
// windowed record before the window opens goes through ST_DIV for the
// bit-serial first-boundary division (33 steps plus hand-over).
// Reset clears the interval register, all window state and the result flag.
// ----------------------------------------------------------------------------
module time_interval_aligner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tia_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [tia_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [tia_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tia_pkg::TimeWidth-1:0]      req_record_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accept,
   output logic                               rsp_window_closed,
   output logic [tia_pkg::BoundWidth-1:0]     rsp_closed_start,
   output logic [tia_pkg::BoundWidth-1:0]     rsp_closed_end,
   output logic [tia_pkg::BoundWidth-1:0]     rsp_current_start,
   output logic [tia_pkg::TimeWidth-1:0]      rsp_last_time
);
   import tia_pkg::*;

   logic [IntervalWidth-1:0] interval_ff;
   logic [CsrIdxWidth-1:0]   csr_idx;
   cmd_type                  cmd;
   status_type               status;

   // Configuration register, one word.
   assign csr_idx = paddr[CsrAddrWidth-1:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (psel && penable && pwrite && (csr_idx == RegIntervalIdx)) begin
         interval_ff <= pwdata[IntervalWidth-1:0];
      end
   end

   always_comb begin
      if (csr_idx == RegIntervalIdx) begin
         prdata = {{(CsrDataWidth-IntervalWidth){1'b0}}, interval_ff};
      end else begin
         prdata = '0;
      end
   end

   tia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tia_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .interval          (interval_ff),
      .record_time       (req_record_time),
      .rsp_accept        (rsp_accept),
      .rsp_window_closed (rsp_window_closed),
      .rsp_closed_start  (rsp_closed_start),
      .rsp_closed_end    (rsp_closed_end),
      .rsp_current_start (rsp_current_start),
      .rsp_last_time     (rsp_last_time)
   );

   // Only one request is in the block at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // A dropped record cannot close a window.
   a_close_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_closed) |-> rsp_accept)
      else $error("window closed by a dropped record");

   // The closed fields are zero unless a window closed.
   a_closed_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_window_closed) |->
      (rsp_closed_start == '0) && (rsp_closed_end == '0))
      else $error("closed window fields set without a close");

   // A closing window hands its end boundary on as the new start.
   a_close_advances: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_closed) |-> (rsp_current_start == rsp_closed_end))
      else $error("new window does not start at the closed boundary");

endmodule

FILE: tb/time_interval_aligner_checker.sv
// ----------------------------------------------------------------------------
// Time interval aligner checker
// Watches the configuration port and the request and report channels of the aligner,
// keeps its own copy of the window state, predicts one report per accepted
// request and compares every returned report with the oldest prediction.
// ----------------------------------------------------------------------------
module time_interval_aligner_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tia_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [tia_pkg::CsrDataWidth-1:0]   pwdata,
   input  logic [tia_pkg::CsrDataWidth-1:0]   prdata,
   input  logic                               pready,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [tia_pkg::TimeWidth-1:0]      req_record_time,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_accept,
   input  logic                               rsp_window_closed,
   input  logic [tia_pkg::BoundWidth-1:0]     rsp_closed_start,
   input  logic [tia_pkg::BoundWidth-1:0]     rsp_closed_end,
   input  logic [tia_pkg::BoundWidth-1:0]     rsp_current_start,
   input  logic [tia_pkg::TimeWidth-1:0]      rsp_last_time,
   output int unsigned                        pending,
   output int unsigned                        errors,
   output int unsigned                        closes,
   output int unsigned                        drops
);

   import tia_pkg::*;

   // One predicted window report.
   typedef struct packed {
      logic                  accept;
      logic                  window_closed;
      logic [BoundWidth-1:0] closed_start;
      logic [BoundWidth-1:0] closed_end;
      logic [BoundWidth-1:0] current_start;
      logic [TimeWidth-1:0]  last_time;
   } window_report_type;

   window_report_type expected_reports[$];

   // Shadow copy of the interval register and of the window state.
   logic [IntervalWidth-1:0] interval_cfg;
   logic [TimeWidth-1:0]     peak_time;
   logic [BoundWidth-1:0]    first_edge;
   logic                     first_edge_known;
   logic                     windowing_started;
   logic [BoundWidth-1:0]    open_start;
   logic [BoundWidth-1:0]    open_end;
   logic [TimeWidth-1:0]     newest_time;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned close_count;
   int unsigned drop_count;

   assign pending = outstanding;
   assign errors  = mismatches;
   assign closes  = close_count;
   assign drops   = drop_count;

   // Moves the window state on by one record and returns the report it causes.
   function automatic window_report_type advance_window(input logic [TimeWidth-1:0] stamp);
      window_report_type        report;
      logic [63:0]              rounded;
      logic [IntervalWidth-1:0] span;
      report        = '0;
      report.accept = 1'b1;
      span          = interval_cfg;
      if (stamp > peak_time) begin
         peak_time = stamp;
      end
      if (span == '0) begin
         // Windowing off: only the first and the latest time are kept.
         if (!windowing_started) begin
            open_start        = {1'b0, peak_time};
            windowing_started = 1'b1;
         end
         newest_time = peak_time;
      end else begin
         if (!windowing_started) begin
            // The first record fixes the first boundary, rounded up.
            if (!first_edge_known) begin
               rounded = ((64'(peak_time) + 64'(span) - 64'd1) / 64'(span)) * 64'(span);
               first_edge       = rounded[BoundWidth-1:0];
               first_edge_known = 1'b1;
            end
            if ({1'b0, peak_time} < first_edge) begin
               report.accept = 1'b0;
            end else begin
               open_start        = first_edge;
               open_end          = first_edge + BoundWidth'(span);
               windowing_started = 1'b1;
            end
         end
         if (report.accept) begin
            // At most one window closes per record, however far time jumped.
            if ({1'b0, peak_time} >= open_end) begin
               report.window_closed = 1'b1;
               report.closed_start  = open_start;
               report.closed_end    = open_end;
               open_start           = open_end;
               open_end             = open_end + BoundWidth'(span);
            end
            newest_time = peak_time;
         end
      end
      report.current_start = open_start;
      report.last_time     = newest_time;
      return report;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   // Everything is sampled at the rising edge, before the stimulus moves on.
   always @(posedge clock) begin
      window_report_type want;
      if (reset) begin
         expected_reports.delete();
         interval_cfg      = '0;
         peak_time         = '0;
         first_edge        = '0;
         first_edge_known  = 1'b0;
         windowing_started = 1'b0;
         open_start        = '0;
         open_end          = '0;
         newest_time       = '0;
         outstanding       = 0;
         mismatches        = 0;
         close_count       = 0;
         drop_count        = 0;
      end else begin
         // Register accesses; other indexes are not decoded.
         if (psel && penable && pready
             && paddr[CsrAddrWidth-1:2] == RegIntervalIdx) begin
            if (pwrite) begin
               interval_cfg = pwdata[IntervalWidth-1:0];
            end else begin
               check_field("interval_seconds", 64'(interval_cfg), 64'(prdata));
            end
         end

         // Returned reports are matched against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report returned with no request outstanding");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               outstanding--;
               check_field("accept", 64'(want.accept), 64'(rsp_accept));
               check_field("window_closed", 64'(want.window_closed),
                           64'(rsp_window_closed));
               check_field("closed_start", 64'(want.closed_start), 64'(rsp_closed_start));
               check_field("closed_end", 64'(want.closed_end), 64'(rsp_closed_end));
               check_field("current_start", 64'(want.current_start),
                           64'(rsp_current_start));
               check_field("last_time", 64'(want.last_time), 64'(rsp_last_time));
            end
         end

         // Each accepted request yields exactly one report.
         if (req_valid && req_ready) begin
            want = advance_window(req_record_time);
            if (!want.accept) begin
               drop_count++;
            end
            if (want.window_closed) begin
               close_count++;
            end
            expected_reports.push_back(want);
            outstanding++;
         end
      end
   end

endmodule

FILE: tb/tb_time_interval_aligner.sv
// ----------------------------------------------------------------------------
// Time interval aligner testbench
// Drives record timestamps into the aligner under a range of window
// intervals, with random gaps on the request side and random back-pressure on
// the report side. A checker beside the block predicts and compares every
// report; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_time_interval_aligner;

   import tia_pkg::*;

   // An index past the register list; writes there must be ignored.
   localparam logic [CsrIdxWidth-1:0] UnusedRegIdx = 1'b1;
   localparam int SegmentRequests = 195;
   localparam int TailRequests    = 80;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CsrAddrWidth-1:0]  paddr;
   logic [CsrDataWidth-1:0]  pwdata;
   logic [CsrDataWidth-1:0]  prdata;
   logic                     pready;
   logic                     req_valid;
   logic                     req_ready;
   logic [TimeWidth-1:0]     req_record_time;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_accept;
   logic                     rsp_window_closed;
   logic [BoundWidth-1:0]    rsp_closed_start;
   logic [BoundWidth-1:0]    rsp_closed_end;
   logic [BoundWidth-1:0]    rsp_current_start;
   logic [TimeWidth-1:0]     rsp_last_time;

   int unsigned pending;
   int unsigned errors;
   int unsigned closes;
   int unsigned drops;
   int unsigned requests_sent;
   logic        calm;
   logic [TimeWidth-1:0] stream_time;

   time_interval_aligner dut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_record_time   (req_record_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accept        (rsp_accept),
      .rsp_window_closed (rsp_window_closed),
      .rsp_closed_start  (rsp_closed_start),
      .rsp_closed_end    (rsp_closed_end),
      .rsp_current_start (rsp_current_start),
      .rsp_last_time     (rsp_last_time)
   );

   time_interval_aligner_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_record_time   (req_record_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accept        (rsp_accept),
      .rsp_window_closed (rsp_window_closed),
      .rsp_closed_start  (rsp_closed_start),
      .rsp_closed_end    (rsp_closed_end),
      .rsp_current_start (rsp_current_start),
      .rsp_last_time     (rsp_last_time),
      .pending           (pending),
      .errors            (errors),
      .closes            (closes),
      .drops             (drops)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The report side stalls about a quarter of the time, except when calm.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
   end

   // Adds a step to a timestamp, saturating at the top of the 32-bit range.
   function automatic logic [TimeWidth-1:0] later_time(input logic [TimeWidth-1:0] base,
                                                       input logic [63:0] step);
      logic [63:0] sum;
      sum = 64'(base) + step;
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[TimeWidth-1:0];
   endfunction

   // Presents one request and holds it until it is taken. Valid is only
   // lowered for a gap, so back-to-back requests keep it high.
   task automatic send_record(input logic [TimeWidth-1:0] stamp);
      logic taken;
      if (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 26);
      end
      req_valid       <= 1'b1;
      req_record_time <= stamp;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      requests_sent++;
   endtask

   // Mostly forward steps of up to one interval, with stale records, repeats
   // and jumps over several intervals mixed in.
   task automatic send_stream_record(input logic [31:0] span);
      int unsigned          pick;
      logic [TimeWidth-1:0] stamp;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         stream_time = later_time(stream_time, 64'($urandom_range(0, span)));
         stamp       = stream_time;
      end else if (pick < 82) begin
         stamp = $urandom_range(0, stream_time);
      end else if (pick < 95) begin
         stamp = stream_time;
      end else begin
         stream_time = later_time(stream_time, 64'(span) * $urandom_range(2, 5)
                                  + $urandom_range(0, span));
         stamp       = stream_time;
      end
      send_record(stamp);
   endtask

   // Stops requests and waits for every report to come back.
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Writes a register, reads it back, then leaves the bus idle.
   task automatic program_register(input logic [CsrIdxWidth-1:0] idx,
                                   input logic [CsrDataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stimulus.
   initial begin
      logic        zero_start;
      logic [31:0] span;
      reset           <= 1'b1;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      req_valid       <= 1'b0;
      req_record_time <= '0;
      calm            <= 1'b0;
      requests_sent   = 0;
      zero_start      = ($urandom_range(0, 3) == 0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // In some runs the stream starts with windowing off, so the first
      // windowed record closes a window that ends at zero.
      if (zero_start) begin
         send_record(32'd1000);
         send_record(32'd500);
         drain_requests();
      end

      // First boundary rounding, drops before it, a stale zero time, a skip
      // over several intervals and a stale record while windowing.
      program_register(RegIntervalIdx, 32'd7);
      send_record(32'd1000);
      send_record(32'd0);
      send_record(32'd1000);
      send_record(32'd1001);
      send_record(32'd1007);
      send_record(32'd1008);
      send_record(32'd1030);
      send_record(32'd1010);
      send_record(32'd1031);
      send_record(32'd1032);

      // Windowing switched off after it started, then a write past the list.
      drain_requests();
      program_register(RegIntervalIdx, 32'd0);
      send_record(32'd1040);
      send_record(32'd1035);
      drain_requests();
      program_register(UnusedRegIdx, 32'hFFFF_FFFF);
      send_record(32'd1041);

      // Smallest interval, switched on again after a pause in windowing.
      drain_requests();
      program_register(RegIntervalIdx, 32'd1);
      send_record(32'd1041);
      send_record(32'd1045);
      send_record(32'd1046);
      stream_time = 32'd1046;

      // Random segments, intervals mostly rising so the window keeps pace.
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0:       span = 32'd1;
            1:       span = $urandom_range(2, 60);
            2:       span = $urandom_range(61, 5000);
            3:       span = 32'd0;
            4:       span = 32'd86400;
            5:       span = $urandom_range(20000, 86400);
            6:       span = 32'h1_FFFF;
            default: span = $urandom_range(86401, 32'h1_FFFF);
         endcase
         drain_requests();
         program_register(RegIntervalIdx, span);
         calm <= (seg == 2);
         for (int n = 0; n < SegmentRequests; n++) begin
            send_stream_record((span == 0) ? 32'd1000 : span);
         end
      end

      // Near the top of the time range the window lags far behind, so every
      // record closes one window; stale records here toggle every time bit.
      calm        <= 1'b0;
      stream_time = later_time(32'hFFF0_0000, 64'($urandom_range(0, 32'h000F_0000)));
      for (int n = 0; n < TailRequests; n++) begin
         send_stream_record(span);
      end
      send_record(32'hFFFF_FFFF);
      send_record(32'hFFFF_FFFF);
      send_record(32'd0);

      drain_requests();
      repeat (8) @(posedge clock);
      $display("Run covered %0d requests over intervals from 0 to 131071", requests_sent);
      $display("with %0d windows closed and %0d records dropped.", closes, drops);
      if (errors == 0) begin
         $display("tb_time_interval_aligner: PASS");
      end else begin
         $display("tb_time_interval_aligner: FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("tb_time_interval_aligner: FAIL");
      $finish;
   end

endmodule
